// ===== hw/rtl/mmf_pkg.sv =====
// ----------------------------------------------------------------------------
// mmf_pkg
// Shared sizes, byte codes, length tables and types of the MIDI framer.
// ----------------------------------------------------------------------------
package mmf_pkg;

  localparam int MAX_CHUNK   = 32;
  localparam int CNT_W       = $clog2(MAX_CHUNK + 1);
  localparam int ADDR_W      = $clog2(MAX_CHUNK);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_W      = 6;
  localparam int CMP_W      = 8;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CFG_W-1:0] CHUNK_RESET = CFG_W'(32);
  localparam logic             REG_CHUNK   = 1'b0;

  localparam logic [7:0] RT_MIN      = 8'hF8;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] COMMON_MIN  = 8'hF1;

  typedef struct packed {
    logic              flush;
    logic [7:0]        data;
    logic [CNT_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } back_stat_t;

  function automatic logic [1:0] chan_len(input logic [2:0] idx);
    logic [1:0] len;
    case (idx)
      3'd4, 3'd5: len = 2'd2;
      3'd7:       len = 2'd0;
      default:    len = 2'd3;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] common_len(input logic [2:0] idx);
    logic [1:0] len;
    case (idx)
      3'd1, 3'd3:       len = 2'd2;
      3'd2:             len = 2'd3;
      3'd4, 3'd5, 3'd6: len = 2'd1;
      default:          len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/mmf_ram.sv =====
// ----------------------------------------------------------------------------
// mmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mmf_queue.sv =====
// ----------------------------------------------------------------------------
// mmf_queue
// Short command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module mmf_queue
  import mmf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/mmf_front.sv =====
// ----------------------------------------------------------------------------
// mmf_front
// Classify input bytes, track running status and SysEx, fill the message
// buffer and queue emit commands.
// ----------------------------------------------------------------------------
module mmf_front
  import mmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic [CFG_W-1:0] chunk_size,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_cmd,
  output ram_wr_t          ram_wr,
  input  back_stat_t       back_stat,
  output logic             flush_busy
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       exp_r, exp_nxt;
  logic             sx_r, sx_nxt;
  logic [7:0]       rs_r, rs_nxt;
  logic             fl_r, fl_nxt;

  logic             acc;
  logic [CMP_W-1:0] cfg_ext, lim;
  logic [CNT_W-1:0] cnt1, cnt_eff;
  logic [1:0]       exp_eff;

  assign in_tready  = !q_full && !fl_r;
  assign acc        = in_tvalid && in_tready;
  assign flush_busy = fl_r;

  always_comb begin
    cfg_ext = CMP_W'(chunk_size);
    if (cfg_ext < CMP_W'(2)) begin
      lim = CMP_W'(2);
    end else if (cfg_ext > CMP_W'(MAX_CHUNK)) begin
      lim = CMP_W'(MAX_CHUNK);
    end else begin
      lim = cfg_ext;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    exp_nxt = exp_r;
    sx_nxt  = sx_r;
    rs_nxt  = rs_r;
    fl_nxt  = fl_r && !back_stat.done;
    q_push  = 1'b0;
    q_cmd   = '0;
    ram_wr  = '0;
    cnt1    = '0;
    cnt_eff = cnt_r;
    exp_eff = exp_r;
    if (acc) begin
      if (in_tdata >= RT_MIN) begin
        q_push     = 1'b1;
        q_cmd.data = in_tdata;
        q_cmd.len  = CNT_W'(1);
      end else if (in_tdata == SYSEX_END) begin
        if (sx_r) begin
          ram_wr      = '{we: 1'b1, addr: cnt_r[ADDR_W-1:0], data: in_tdata};
          q_push      = 1'b1;
          q_cmd.flush = 1'b1;
          q_cmd.len   = cnt_r + 1'b1;
          sx_nxt      = 1'b0;
          rs_nxt      = '0;
          cnt_nxt     = '0;
          fl_nxt      = 1'b1;
        end
      end else if (sx_r) begin
        ram_wr = '{we: 1'b1, addr: cnt_r[ADDR_W-1:0], data: in_tdata};
        cnt1   = cnt_r + 1'b1;
        if (CMP_W'(cnt1) >= lim) begin
          q_push      = 1'b1;
          q_cmd.flush = 1'b1;
          q_cmd.len   = cnt1;
          cnt_nxt     = '0;
          fl_nxt      = 1'b1;
        end else begin
          cnt_nxt = cnt1;
        end
      end else if (in_tdata[7]) begin
        ram_wr = '{we: 1'b1, addr: '0, data: in_tdata};
        if (in_tdata == SYSEX_START) begin
          sx_nxt  = 1'b1;
          cnt_nxt = CNT_W'(1);
          rs_nxt  = '0;
          exp_nxt = '0;
        end else if (in_tdata >= COMMON_MIN) begin
          rs_nxt  = '0;
          exp_nxt = common_len(in_tdata[2:0]);
          if (common_len(in_tdata[2:0]) == 2'd1) begin
            q_push      = 1'b1;
            q_cmd.flush = 1'b1;
            q_cmd.len   = CNT_W'(1);
            cnt_nxt     = '0;
            fl_nxt      = 1'b1;
          end else begin
            cnt_nxt = CNT_W'(1);
          end
        end else begin
          rs_nxt  = in_tdata;
          exp_nxt = chan_len(in_tdata[6:4]);
          cnt_nxt = CNT_W'(1);
        end
      end else if (cnt_r != '0 || rs_r != '0) begin
        // buffer slot 0 already holds the running status byte
        if (cnt_r == '0) begin
          cnt_eff = CNT_W'(1);
          exp_eff = chan_len(rs_r[6:4]);
          cnt_nxt = cnt_eff;
          exp_nxt = exp_eff;
        end
        if (exp_eff != '0 && cnt_eff < CNT_W'(exp_eff)) begin
          ram_wr = '{we: 1'b1, addr: cnt_eff[ADDR_W-1:0], data: in_tdata};
          cnt1   = cnt_eff + 1'b1;
          if (cnt1 == CNT_W'(exp_eff)) begin
            q_push      = 1'b1;
            q_cmd.flush = 1'b1;
            q_cmd.len   = cnt1;
            cnt_nxt     = '0;
            fl_nxt      = 1'b1;
          end else begin
            cnt_nxt = cnt1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      exp_r <= '0;
      sx_r  <= 1'b0;
      rs_r  <= '0;
      fl_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
      sx_r  <= sx_nxt;
      rs_r  <= rs_nxt;
      fl_r  <= fl_nxt;
    end
  end

endmodule

// ===== hw/rtl/mmf_back.sv =====
// ----------------------------------------------------------------------------
// mmf_back
// Pop emit commands, stream single bytes or buffered runs to the output.
// ----------------------------------------------------------------------------
module mmf_back
  import mmf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  cmd_t              q_head,
  output logic              q_pop,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output back_stat_t        stat,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic             vld_r, vld_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             last_r, last_nxt;
  logic             out_free, is_last;

  assign out_free  = !vld_r || out_tready;
  assign is_last   = (idx_r + 1'b1) == len_r;
  assign ram_raddr = idx_r[ADDR_W-1:0];

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    vld_nxt   = vld_r && !out_tready;
    data_nxt  = data_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    stat      = '{busy: (state_r != ST_IDLE), done: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (q_not_empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.flush) begin
            idx_nxt   = '0;
            len_nxt   = q_head.len;
            state_nxt = ST_FETCH;
          end else begin
            vld_nxt  = 1'b1;
            data_nxt = q_head.data;
            last_nxt = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          vld_nxt  = 1'b1;
          data_nxt = ram_rdata;
          last_nxt = is_last;
          if (is_last) begin
            stat.done = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    idx_r  <= idx_nxt;
    len_r  <= len_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

// ===== hw/rtl/midi_message_framer.sv =====
// ----------------------------------------------------------------------------
// midi_message_framer
// MIDI byte stream to framed messages with running status and SysEx chunks.
//
//   channel  dir  word contents
//   in_      in   tdata[7:0] in_byte
//   out_     out  tdata[7:0] out_byte, tlast last_of_run
//   cfg_     in   reg 0 at 0x0: sysex_chunk_size[5:0]
//
// An input byte is classified combinationally when it is accepted. A real-time
// word is queued and then loaded into the output register. A byte that
// completes a buffered run (message, single-byte common or SysEx chunk)
// starts a read of the buffer RAM: each word of the run takes a RAM read and
// an output load, and waits longer under out_tready stalls. The input is held
// off until the last word of the run is loaded, and while the queue is full.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module midi_message_framer
  import mmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] in_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] out_byte
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [CFG_W-1:0] chunk_r, chunk_nxt;
  logic             q_full, q_push, q_pop, q_not_empty;
  cmd_t             q_cmd, q_head;
  ram_wr_t          ram_wr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  back_stat_t       back_stat;
  logic             flush_busy;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CHUNK) ? APB_DATA_W'(chunk_r) : '0;

  always_comb begin
    chunk_nxt = chunk_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == REG_CHUNK) begin
      chunk_nxt = cfg_pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= CHUNK_RESET;
    end else begin
      chunk_r <= chunk_nxt;
    end
  end

  mmf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .chunk_size (chunk_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd),
    .ram_wr     (ram_wr),
    .back_stat  (back_stat),
    .flush_busy (flush_busy)
  );

  mmf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mmf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CHUNK)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mmf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .stat        (back_stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  a_no_write_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.busy |-> !ram_wr.we)
    else $error("buffer written while a run is being read");

  a_done_matches_flush: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.done |-> flush_busy)
    else $error("run completed without an outstanding flush");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_done_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.done |=> !flush_busy)
    else $error("input still held after run completed");

endmodule
